>>> design/x25519_pkg.sv
package x25519_pkg;

    // field and ladder constants
    localparam int unsigned LADDER_BITS = 256;
    localparam int unsigned BIT_W       = 8;
    localparam int unsigned PC_W        = 5;
    localparam int unsigned INIT_LEN    = 6;
    localparam int unsigned STEP_LEN    = 18;
    localparam int unsigned INV_TOP     = 253;

    // p = 2^255 - 19
    localparam logic [255:0] P_MOD = {1'b0, {247{1'b1}}, 8'hed};
    localparam logic [255:0] A24   = 256'd121665;
    localparam logic [255:0] BASE_U = 256'd9;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_CLAMP = 1'b0,
        CFG_BASE  = 1'b1
    } t_cfg;

    // register file slots
    typedef enum logic [3:0] {
        S_X1, S_X2, S_Z2, S_X3, S_Z3, S_A, S_B, S_AA,
        S_BB, S_E, S_C, S_D, S_DA, S_CB, S_T, S_K
    } t_slot;

    typedef enum logic [2:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_MOV, OP_CONST, OP_LDU, OP_OUT
    } t_op;

    typedef enum logic [1:0] {
        K_ZERO, K_ONE, K_A24
    } t_cnst;

    typedef struct packed {
        t_op   op;
        t_slot dst;
        t_slot src_a;
        t_slot src_b;
        t_cnst cnst;
    } t_uop;

    // controller to datapath
    typedef struct packed {
        logic             valid;
        logic             load;
        t_uop             uop;
        logic [BIT_W-1:0] bit_idx;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic done;
        logic k_bit;
        logic out_busy;
    } t_sts;

    function automatic t_uop mk(input t_op op, input t_slot d, input t_slot a,
                                input t_slot b);
        t_uop u;
        u.op    = op;
        u.dst   = d;
        u.src_a = a;
        u.src_b = b;
        u.cnst  = K_ZERO;
        return u;
    endfunction

    function automatic t_uop mkc(input t_slot d, input t_cnst c);
        t_uop u;
        u      = mk(OP_CONST, d, d, d);
        u.cnst = c;
        return u;
    endfunction

    // set-up sequence before the ladder
    function automatic t_uop init_uop(input logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            5'd0:    u = mk(OP_LDU, S_X1, S_X1, S_X1);
            5'd1:    u = mkc(S_X2, K_ONE);
            5'd2:    u = mkc(S_Z2, K_ZERO);
            5'd3:    u = mk(OP_MOV, S_X3, S_X1, S_X1);
            5'd4:    u = mkc(S_Z3, K_ONE);
            default: u = mkc(S_K, K_A24);
        endcase
        return u;
    endfunction

    // one ladder step, in logical slots
    function automatic t_uop step_uop(input logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            5'd0:    u = mk(OP_ADD, S_A,  S_X2, S_Z2);
            5'd1:    u = mk(OP_MUL, S_AA, S_A,  S_A);
            5'd2:    u = mk(OP_SUB, S_B,  S_X2, S_Z2);
            5'd3:    u = mk(OP_MUL, S_BB, S_B,  S_B);
            5'd4:    u = mk(OP_SUB, S_E,  S_AA, S_BB);
            5'd5:    u = mk(OP_ADD, S_C,  S_X3, S_Z3);
            5'd6:    u = mk(OP_SUB, S_D,  S_X3, S_Z3);
            5'd7:    u = mk(OP_MUL, S_DA, S_D,  S_A);
            5'd8:    u = mk(OP_MUL, S_CB, S_C,  S_B);
            5'd9:    u = mk(OP_ADD, S_X3, S_DA, S_CB);
            5'd10:   u = mk(OP_MUL, S_X3, S_X3, S_X3);
            5'd11:   u = mk(OP_SUB, S_T,  S_DA, S_CB);
            5'd12:   u = mk(OP_MUL, S_T,  S_T,  S_T);
            5'd13:   u = mk(OP_MUL, S_Z3, S_T,  S_X1);
            5'd14:   u = mk(OP_MUL, S_X2, S_AA, S_BB);
            5'd15:   u = mk(OP_MUL, S_T,  S_E,  S_K);
            5'd16:   u = mk(OP_ADD, S_T,  S_AA, S_T);
            default: u = mk(OP_MUL, S_Z2, S_E,  S_T);
        endcase
        return u;
    endfunction

    // conditional swap done by renaming the ladder slots
    function automatic t_slot remap(input t_slot s, input logic swap);
        t_slot r;
        r = s;
        if (swap) begin
            case (s)
                S_X2:    r = S_X3;
                S_X3:    r = S_X2;
                S_Z2:    r = S_Z3;
                S_Z3:    r = S_Z2;
                default: r = s;
            endcase
        end
        return r;
    endfunction

endpackage

>>> design/x25519_ctrl.sv
module x25519_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_idle,
    output x25519_pkg::t_cmd o_cmd,
    input  x25519_pkg::t_sts i_sts
);
    import x25519_pkg::*;

    typedef enum logic [1:0] {C_IDLE, C_LOAD, C_ISSUE, C_WAIT} t_state;
    typedef enum logic [1:0] {PH_INIT, PH_LADDER, PH_INV, PH_FINAL} t_phase;

    t_state           r_state;
    t_phase           r_phase;
    logic [PC_W-1:0]  r_pc;
    logic [BIT_W-1:0] r_bit;
    logic [7:0]       r_inv_i;
    logic             r_sq;

    t_uop uop;
    t_uop raw;
    logic issue_ok;
    logic skip_mul;

    // current operation
    always_comb begin
        raw = step_uop(r_pc);
        uop = init_uop(r_pc);
        case (r_phase)
            PH_INIT: uop = init_uop(r_pc);
            PH_LADDER: begin
                uop       = raw;
                uop.dst   = remap(raw.dst, i_sts.k_bit);
                uop.src_a = remap(raw.src_a, i_sts.k_bit);
                uop.src_b = remap(raw.src_b, i_sts.k_bit);
            end
            PH_INV: begin
                if (r_pc == '0) uop = mk(OP_MOV, S_A, S_Z2, S_Z2);
                else if (r_sq)  uop = mk(OP_MUL, S_A, S_A, S_A);
                else            uop = mk(OP_MUL, S_A, S_A, S_Z2);
            end
            PH_FINAL: begin
                if (r_pc == '0) uop = mk(OP_MUL, S_A, S_X2, S_A);
                else            uop = mk(OP_OUT, S_A, S_A, S_A);
            end
            default: uop = init_uop(r_pc);
        endcase
    end

    assign issue_ok      = !((uop.op == OP_OUT) && i_sts.out_busy);
    assign skip_mul      = (r_inv_i == 8'd2) || (r_inv_i == 8'd4);
    assign o_cmd.valid   = (r_state == C_ISSUE) && issue_ok;
    assign o_cmd.load    = (r_state == C_LOAD);
    assign o_cmd.uop     = uop;
    assign o_cmd.bit_idx = r_bit;
    assign o_idle        = (r_state == C_IDLE);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_phase <= PH_INIT;
            r_pc    <= '0;
            r_bit   <= '0;
            r_inv_i <= '0;
            r_sq    <= 1'b0;
        end else begin
            case (r_state)
                C_IDLE: begin
                    if (i_start) r_state <= C_LOAD;
                end
                C_LOAD: begin
                    r_phase <= PH_INIT;
                    r_pc    <= '0;
                    r_state <= C_ISSUE;
                end
                C_ISSUE: begin
                    if (issue_ok) r_state <= C_WAIT;
                end
                C_WAIT: begin
                    if (i_sts.done) begin
                        r_state <= C_ISSUE;
                        case (r_phase)
                            PH_INIT: begin
                                if (r_pc == PC_W'(INIT_LEN - 1)) begin
                                    r_phase <= PH_LADDER;
                                    r_pc    <= '0;
                                    r_bit   <= BIT_W'(LADDER_BITS - 1);
                                end else begin
                                    r_pc <= r_pc + 1'b1;
                                end
                            end
                            PH_LADDER: begin
                                if (r_pc == PC_W'(STEP_LEN - 1)) begin
                                    r_pc <= '0;
                                    if (r_bit == '0) r_phase <= PH_INV;
                                    else             r_bit <= r_bit - 1'b1;
                                end else begin
                                    r_pc <= r_pc + 1'b1;
                                end
                            end
                            PH_INV: begin
                                if (r_pc == '0) begin
                                    r_pc    <= PC_W'(1);
                                    r_inv_i <= 8'(INV_TOP);
                                    r_sq    <= 1'b1;
                                end else if (r_sq && !skip_mul) begin
                                    r_sq <= 1'b0;
                                end else if (r_inv_i == '0) begin
                                    r_phase <= PH_FINAL;
                                    r_pc    <= '0;
                                end else begin
                                    r_inv_i <= r_inv_i - 1'b1;
                                    r_sq    <= 1'b1;
                                end
                            end
                            PH_FINAL: begin
                                if (r_pc == '0) r_pc <= PC_W'(1);
                                else            r_state <= C_IDLE;
                            end
                            default: r_state <= C_IDLE;
                        endcase
                    end
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    a_idle_no_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == C_IDLE) |-> !o_cmd.valid)
        else $error("command issued while idle");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.done |-> (r_state == C_WAIT))
        else $error("datapath done outside wait");

    a_cmd_then_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.valid |=> (r_state == C_WAIT) && !o_cmd.valid)
        else $error("command not followed by wait");

endmodule

>>> design/x25519_dp.sv
module x25519_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_fire,
    input  logic [1:0]       i_word_index,
    input  logic [63:0]      i_scalar_word,
    input  logic [63:0]      i_point_word,
    input  logic             i_cfg_we,
    input  logic [0:0]       i_cfg_index,
    input  logic [0:0]       i_cfg_data,
    input  x25519_pkg::t_cmd i_cmd,
    output x25519_pkg::t_sts o_sts,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [63:0]      o_result_word,
    output logic [1:0]       o_result_index,
    output logic             o_last_word
);
    import x25519_pkg::*;

    typedef enum logic [3:0] {
        D_IDLE, D_EXEC, D_MUL, D_DRAIN, D_TOP,
        D_RED1, D_RED2, D_RED3, D_RED4, D_RED5, D_RED6
    } t_state;

    t_state        r_state;
    t_uop          r_uop;
    logic          r_done;
    logic          r_clamp;
    logic          r_base;
    logic [63:0]   r_scalar [4];
    logic [63:0]   r_point  [4];
    logic [255:0]  r_k;
    logic [255:0]  r_uf;
    logic [255:0]  r_rf [16];
    logic [255:0]  r_rda;
    logic [255:0]  r_rdb;
    logic [3:0]    r_col;
    logic [2:0]    r_i;
    logic [63:0]   r_prod;
    logic          r_pv;
    logic          r_plast;
    logic [69:0]   r_acc;
    logic [511:0]  r_wide;
    logic [262:0]  r_s;
    logic [255:0]  r_res;
    logic [1:0]    r_ocnt;
    logic          r_obusy;

    logic [255:0]  k_cl;
    logic [255:0]  u_raw;
    logic [255:0]  u_fold;
    logic [255:0]  opa;
    logic [255:0]  opb;
    logic [256:0]  add_s;
    logic [256:0]  add_d;
    logic [256:0]  sub_d;
    logic [255:0]  cnst_v;
    logic [255:0]  exec_v;
    logic [256:0]  fin_d;
    logic [2:0]    col_lo1;
    logic [2:0]    col_hi;
    logic [3:0]    col_nx;
    logic [2:0]    j_idx;
    logic [31:0]   a_limb;
    logic [31:0]   b_limb;
    logic [63:0]   prod;
    logic          col_last;
    logic [69:0]   acc_sum;
    logic [12:0]   fold38;
    logic [6:0]    fold19;
    logic          w_en;
    logic [255:0]  w_data;

    // scalar, clamped when enabled, and reduced input point
    always_comb begin
        k_cl = {r_scalar[3], r_scalar[2], r_scalar[1], r_scalar[0]};
        u_raw = r_base ? BASE_U : {r_point[3], r_point[2], r_point[1], r_point[0]};
        if (r_clamp) begin
            k_cl[2:0] = 3'b000;
            k_cl[255] = 1'b0;
            k_cl[254] = 1'b1;
            u_raw[255] = 1'b0;
        end
        u_fold = {1'b0, u_raw[254:0]} + (u_raw[255] ? 256'd19 : 256'd0);
    end

    // add / sub / move / constant / load of u
    assign opa   = (r_uop.op == OP_LDU) ? r_uf : r_rda;
    assign opb   = r_rdb;
    assign add_s = {1'b0, opa} + {1'b0, opb};
    assign add_d = add_s - {1'b0, P_MOD};
    assign sub_d = {1'b0, opa} - {1'b0, opb};
    assign fin_d = {1'b0, r_s[255:0]} - {1'b0, P_MOD};

    always_comb begin
        case (r_uop.cnst)
            K_ONE:   cnst_v = 256'd1;
            K_A24:   cnst_v = A24;
            default: cnst_v = '0;
        endcase
        case (r_uop.op)
            OP_ADD:   exec_v = add_d[256] ? add_s[255:0] : add_d[255:0];
            OP_SUB:   exec_v = sub_d[256] ? (sub_d[255:0] + P_MOD) : sub_d[255:0];
            OP_CONST: exec_v = cnst_v;
            OP_LDU: begin
                exec_v = {1'b0, opa} >= {1'b0, P_MOD} ? (opa - P_MOD) : opa;
            end
            default:  exec_v = opa;
        endcase
    end

    // product scanning over 32-bit limbs
    assign col_hi   = (r_col > 4'd7) ? 3'd7 : r_col[2:0];
    assign col_nx   = r_col + 4'd1;
    assign col_lo1  = (col_nx > 4'd7) ? 3'(col_nx - 4'd7) : 3'd0;
    assign j_idx    = 3'(r_col - {1'b0, r_i});
    assign a_limb   = opa[{r_i, 5'b0} +: 32];
    assign b_limb   = opb[{j_idx, 5'b0} +: 32];
    assign prod     = {32'b0, a_limb} * {32'b0, b_limb};
    assign col_last = (r_i == col_hi);
    assign acc_sum  = r_acc + (r_pv ? {6'b0, r_prod} : 70'd0);
    assign fold38   = 13'(r_s[262:256]) * 13'd38;
    assign fold19   = 7'(r_s[256:255]) * 7'd19;

    // register file write
    assign w_en   = ((r_state == D_EXEC) && (r_uop.op != OP_OUT)) || (r_state == D_RED6);
    assign w_data = (r_state == D_RED6) ? (fin_d[256] ? r_s[255:0] : fin_d[255:0]) : exec_v;

    always_ff @(posedge i_clk) begin
        if (w_en) r_rf[r_uop.dst] <= w_data;
        if (i_cmd.valid) begin
            r_rda <= r_rf[i_cmd.uop.src_a];
            r_rdb <= r_rf[i_cmd.uop.src_b];
        end
    end

    // input word stores, configuration and working scalar
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp <= 1'b1;
            r_base  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CLAMP: r_clamp <= i_cfg_data[0];
                CFG_BASE:  r_base  <= i_cfg_data[0];
                default:   r_base  <= r_base;
            endcase
        end
        if (i_in_fire) begin
            r_scalar[i_word_index] <= i_scalar_word;
            r_point[i_word_index]  <= i_point_word;
        end
        if (i_cmd.load) r_k <= k_cl;
    end

    // operation sequencing, multiplier and reduction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_pv    <= 1'b0;
            r_plast <= 1'b0;
            r_obusy <= 1'b0;
            r_ocnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_obusy && i_ready) begin
                r_ocnt <= r_ocnt + 1'b1;
                if (r_ocnt == 2'd3) r_obusy <= 1'b0;
            end
            case (r_state)
                D_IDLE: begin
                    if (i_cmd.valid) begin
                        r_uop <= i_cmd.uop;
                        r_uf  <= u_fold;
                        r_col <= '0;
                        r_i   <= '0;
                        r_pv  <= 1'b0;
                        r_acc <= '0;
                        r_state <= (i_cmd.uop.op == OP_MUL) ? D_MUL : D_EXEC;
                    end
                end
                D_EXEC: begin
                    if (r_uop.op == OP_OUT) begin
                        r_res   <= opa;
                        r_obusy <= 1'b1;
                        r_ocnt  <= '0;
                    end
                    r_done  <= 1'b1;
                    r_state <= D_IDLE;
                end
                D_MUL: begin
                    r_prod  <= prod;
                    r_pv    <= 1'b1;
                    r_plast <= col_last;
                    if (r_pv && r_plast) begin
                        r_wide <= {acc_sum[31:0], r_wide[511:32]};
                        r_acc  <= acc_sum >> 32;
                    end else begin
                        r_acc <= acc_sum;
                    end
                    if (col_last) begin
                        if (r_col == 4'd14) begin
                            r_state <= D_DRAIN;
                        end else begin
                            r_col <= col_nx;
                            r_i   <= col_lo1;
                        end
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                D_DRAIN: begin
                    r_pv <= 1'b0;
                    if (r_pv && r_plast) begin
                        r_wide <= {acc_sum[31:0], r_wide[511:32]};
                        r_acc  <= acc_sum >> 32;
                    end else begin
                        r_acc <= acc_sum;
                    end
                    r_state <= D_TOP;
                end
                D_TOP: begin
                    r_wide  <= {r_acc[31:0], r_wide[511:32]};
                    r_state <= D_RED1;
                end
                // 2^256 folds back as 38
                D_RED1: begin
                    r_s     <= 263'(r_wide[255:0]) + (263'(r_wide[511:256]) << 5);
                    r_state <= D_RED2;
                end
                D_RED2: begin
                    r_s     <= r_s + (263'(r_wide[511:256]) << 2);
                    r_state <= D_RED3;
                end
                D_RED3: begin
                    r_s     <= r_s + (263'(r_wide[511:256]) << 1);
                    r_state <= D_RED4;
                end
                D_RED4: begin
                    r_s     <= 263'(r_s[255:0]) + 263'(fold38);
                    r_state <= D_RED5;
                end
                // 2^255 folds back as 19
                D_RED5: begin
                    r_s     <= 263'(r_s[254:0]) + 263'(fold19);
                    r_state <= D_RED6;
                end
                D_RED6: begin
                    r_done  <= 1'b1;
                    r_state <= D_IDLE;
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    // status and result words
    assign o_sts.done     = r_done;
    assign o_sts.k_bit    = r_k[i_cmd.bit_idx];
    assign o_sts.out_busy = r_obusy;
    assign o_valid        = r_obusy;
    assign o_result_word  = r_res[{r_ocnt, 6'b0} +: 64];
    assign o_result_index = r_ocnt;
    assign o_last_word    = (r_ocnt == 2'd3);

    a_cmd_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.valid |-> (r_state == D_IDLE))
        else $error("command while datapath busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_obusy && !i_ready) |=> $stable(r_ocnt) && r_obusy)
        else $error("result word moved without acceptance");

    a_red_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == D_RED6) |=> r_done && (r_state == D_IDLE))
        else $error("multiply did not complete");

endmodule

>>> design/x25519_scalar_multiply.sv
// X25519 scalar multiplier. Load the scalar and u coordinate as four little-endian
// 64-bit word pairs; the word at index 3 starts a Montgomery ladder over all scalar
// bits, a Fermat inversion and a canonical reduction, after which four result words
// appear on the output channel, index 0 first, last_word set on index 3. Each
// result word is held until the receiver accepts it. Each ladder bit runs ten
// multiplies and eight add/sub steps. Every field multiply uses the one shared
// 32x32 multiplier for 64 limb products, then drains the accumulator (D_DRAIN,
// D_TOP) and reduces (D_RED1 to D_RED6). Input is not taken during a computation;
// result words already waiting do not hold up the next load. Configuration must be
// written only while idle; the block itself does not enforce this.
module x25519_scalar_multiply (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_word_index,
    input  logic [63:0] i_scalar_word,
    input  logic [63:0] i_point_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_result_word,
    output logic [1:0]  o_result_index,
    output logic        o_last_word,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [0:0]  i_cfg_data
);
    import x25519_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic idle;
    logic in_fire;

    assign o_ready = idle;
    assign in_fire = i_valid && idle;

    x25519_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_fire && (i_word_index == 2'd3)),
        .o_idle  (idle),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    x25519_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_fire      (in_fire),
        .i_word_index   (i_word_index),
        .i_scalar_word  (i_scalar_word),
        .i_point_word   (i_point_word),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result_word  (o_result_word),
        .o_result_index (o_result_index),
        .o_last_word    (o_last_word)
    );

endmodule
